@@ hdl/memory_access_position_generator_top_assert.svh @@
// ----------------------------------------------------------------------------
// memory_access_position_generator_top_assert.svh
// assertion macros shared by the position generator modules
// ----------------------------------------------------------------------------
`ifndef MEMORY_ACCESS_POSITION_GENERATOR_TOP_ASSERT_SVH
`define MEMORY_ACCESS_POSITION_GENERATOR_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MAPG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MAPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mapg_pkg.sv @@
// ----------------------------------------------------------------------------
// mapg_pkg
// widths, register codes and controller/datapath signal groups of the
// memory access position generator
// ----------------------------------------------------------------------------
package mapg_pkg;

  // offset width of the target buffer
  localparam int OFFSET_WIDTH = 32;

  // field and register widths
  localparam int MODE_W = 3;
  localparam int ASZ_W  = 21;
  localparam int SOR_W  = 31;
  localparam int JIT_W  = 31;
  localparam int RAND_W = 31;
  localparam int POS_W  = OFFSET_WIDTH + 1;
  localparam int CUR_W  = OFFSET_WIDTH + 2;

  // random scaling and centered range factor
  localparam int RAND_SCALE   = 128;
  localparam int RANGE_FACTOR = 2;
  localparam int RAND_SHIFT   = $clog2(RAND_SCALE);
  localparam int RANGE_SHIFT  = $clog2(RANGE_FACTOR);

  // centered random term and working value widths
  localparam int C_W   = SOR_W + RANGE_SHIFT;
  localparam int VAL_W = ((CUR_W > C_W + 1) ? CUR_W : C_W + 1) + 2;

  // divider widths
  localparam int DVS_W = (OFFSET_WIDTH > C_W) ? OFFSET_WIDTH : C_W;
  localparam int DIV_W = (RAND_W + RAND_SHIFT > VAL_W) ? RAND_W + RAND_SHIFT : VAL_W;
  localparam int CNT_W = $clog2(DIV_W);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (OFFSET_WIDTH > SOR_W) ? OFFSET_WIDTH : SOR_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ASZ    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST   = 3'd4;

  // register reset values
  localparam logic [MODE_W-1:0] MODE_RESET = 3'd1;
  localparam logic [ASZ_W-1:0]  ASZ_RESET  = 21'd4096;

  // pattern modes
  localparam logic [MODE_W-1:0] MODE_ZERO    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SEQ     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RANDOM  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STRIDE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEARBY  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd5;
  localparam logic [MODE_W-1:0] MODE_JITTER  = 3'd6;

  // request actions
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_NEXT  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic rand_go;
    logic rand_take;
    logic calc;
    logic fold_go;
    logic commit;
  } mapg_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_rand;
    logic need_div;
    logic div_busy;
    logic div_done;
    logic out_free;
  } mapg_sts_t;

endpackage

@@ hdl/mapg_if.sv @@
// ----------------------------------------------------------------------------
// mapg_if
// request and result channels of the memory access position generator
// ----------------------------------------------------------------------------

// request channel: action and random number
interface mapg_in_if;
  import mapg_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [RAND_W-1:0] random_value;

  modport source (output valid, output action, output random_value, input ready);
  modport sink   (input valid, input action, input random_value, output ready);
endinterface

// result channel: access position
interface mapg_out_if;
  import mapg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

@@ hdl/mapg_div.sv @@
// ----------------------------------------------------------------------------
// mapg_div
// restoring remainder unit, one dividend bit per cycle; a zero divisor
// gives a zero remainder
// ----------------------------------------------------------------------------
module mapg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mapg_pkg::DIV_W-1:0] dividend_i,
  input  logic [mapg_pkg::DVS_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [mapg_pkg::DVS_W-1:0] rem_o
);
  import mapg_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  // one shift-subtract step
  always_comb begin
    trial = {rem_q, dvd_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
  end

  // sequencing of the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIV_W-2:0], 1'b0};
      rem_d = (trial >= {1'b0, dvs_q}) ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = (dvs_q == '0) ? '0 : rem_q;

endmodule

@@ hdl/mapg_dp.sv @@
// ----------------------------------------------------------------------------
// mapg_dp
// datapath: configuration registers, running position, pattern arithmetic,
// shared remainder unit and result register
// ----------------------------------------------------------------------------
module mapg_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mapg_pkg::mapg_cmd_t             cmd_i,
  output mapg_pkg::mapg_sts_t             sts_o,
  input  logic                            cfg_we_i,
  input  logic [mapg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mapg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            action_i,
  input  logic [mapg_pkg::RAND_W-1:0]     random_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [mapg_pkg::POS_W-1:0] position_o
);
  import mapg_pkg::*;

  typedef enum logic [1:0] {
    FK_NONE,
    FK_HIGH,
    FK_NEG,
    FK_MOD
  } fold_e;

  // configuration registers
  logic [MODE_W-1:0]       mode_q;
  logic [ASZ_W-1:0]        asz_q;
  logic [SOR_W-1:0]        sor_q;
  logic [JIT_W-1:0]        jit_q;
  logic [OFFSET_WIDTH-1:0] last_q;

  // running state and per-item registers
  logic signed [CUR_W-1:0] cur_q;
  logic                    act_q;
  logic [RAND_W-1:0]       r_q;
  logic signed [C_W-1:0]   c_q;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic signed [POS_W-1:0] res_q, res_d;
  fold_e                   kind_q, kind_d;
  logic                    upd_q, upd_d;
  logic                    out_valid_q;
  logic signed [POS_W-1:0] out_pos_q;

  // operands at working width
  logic signed [VAL_W-1:0] curx, ax, px, lx, cx, remx;
  logic signed [VAL_W-1:0] tgt, alt, neg_val, fin;
  logic [SOR_W-1:0]        half;
  logic                    need_div;
  logic                    div_start;
  logic [DIV_W-1:0]        div_dividend;
  logic [DVS_W-1:0]        div_divisor;
  logic                    div_busy, div_done;
  logic [DVS_W-1:0]        div_rem;

  assign curx    = VAL_W'(cur_q);
  assign ax      = VAL_W'(asz_q);
  assign px      = VAL_W'(sor_q);
  assign lx      = VAL_W'(last_q);
  assign cx      = VAL_W'(c_q);
  assign remx    = VAL_W'(div_rem);
  assign neg_val = -val_q;

  // half range of the centered random term
  assign half = (mode_q == MODE_NEARBY) ? sor_q : jit_q;

  // nearby target and its mirrored alternative
  always_comb begin
    tgt = curx + cx;
    alt = c_q[C_W-1] ? (curx - cx + ax) : (curx - cx - ax);
  end

  // pattern arithmetic for the request in hand
  always_comb begin
    val_d  = '0;
    res_d  = '0;
    kind_d = FK_NONE;
    upd_d  = 1'b0;
    if (act_q == ACT_START) begin
      upd_d = 1'b1;
      case (mode_q)
        MODE_RANDOM:  kind_d = FK_MOD;
        MODE_STRIDE:  val_d = px;
        MODE_NEARBY:  val_d = cx;
        MODE_REVERSE: val_d = lx - px;
        MODE_JITTER: begin
          val_d  = px + cx;
          kind_d = FK_HIGH;
        end
        default:      val_d = '0;
      endcase
    end else begin
      case (mode_q)
        MODE_SEQ: begin
          res_d  = cur_q[POS_W-1:0];
          val_d  = curx + ax;
          kind_d = FK_HIGH;
          upd_d  = 1'b1;
        end
        MODE_RANDOM: kind_d = FK_MOD;
        MODE_STRIDE: begin
          res_d  = cur_q[POS_W-1:0];
          val_d  = curx + ax + px;
          kind_d = FK_HIGH;
          upd_d  = 1'b1;
        end
        MODE_NEARBY: begin
          res_d = ((tgt < 0) || (tgt > lx)) ? alt[POS_W-1:0] : tgt[POS_W-1:0];
        end
        MODE_REVERSE: begin
          res_d  = cur_q[POS_W-1:0];
          val_d  = curx - (ax + px);
          kind_d = FK_NEG;
          upd_d  = 1'b1;
        end
        MODE_JITTER: begin
          res_d  = cur_q[POS_W-1:0];
          val_d  = curx + ax + px + cx;
          kind_d = FK_HIGH;
          upd_d  = 1'b1;
        end
        default: res_d = '0;
      endcase
    end
  end

  // whether the working value must be folded through the remainder unit
  always_comb begin
    case (kind_q)
      FK_HIGH: need_div = (val_q > lx);
      FK_NEG:  need_div = (val_q < 0);
      FK_MOD:  need_div = 1'b1;
      default: need_div = 1'b0;
    endcase
  end

  // final position after folding
  always_comb begin
    case (kind_q)
      FK_HIGH: fin = need_div ? remx : val_q;
      FK_NEG:  fin = need_div ? (lx - remx) : val_q;
      FK_MOD:  fin = remx;
      default: fin = val_q;
    endcase
  end

  // remainder unit operands
  always_comb begin
    div_start = cmd_i.rand_go || cmd_i.fold_go;
    if (cmd_i.rand_go) begin
      div_dividend = DIV_W'(r_q);
      div_divisor  = DVS_W'({half, {RANGE_SHIFT{1'b0}}});
    end else begin
      case (kind_q)
        FK_NEG:  div_dividend = DIV_W'($unsigned(neg_val));
        FK_MOD:  div_dividend = DIV_W'({r_q, {RAND_SHIFT{1'b0}}});
        default: div_dividend = DIV_W'($unsigned(val_q));
      endcase
      div_divisor = DVS_W'(last_q);
    end
  end

  mapg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // configuration writes, running position and result handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RESET;
      asz_q       <= ASZ_RESET;
      sor_q       <= '0;
      jit_q       <= '0;
      last_q      <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:   mode_q <= cfg_data_i[MODE_W-1:0];
          CFG_ASZ:    asz_q  <= cfg_data_i[ASZ_W-1:0];
          CFG_STRIDE: sor_q  <= cfg_data_i[SOR_W-1:0];
          CFG_JITTER: jit_q  <= cfg_data_i[JIT_W-1:0];
          CFG_LAST:   last_q <= cfg_data_i[OFFSET_WIDTH-1:0];
          default:    ;
        endcase
      end
      if (cmd_i.commit && upd_q) begin
        cur_q <= fin[CUR_W-1:0];
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-item payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      r_q   <= random_value_i;
    end
    if (cmd_i.rand_take) begin
      c_q <= C_W'(div_rem) - C_W'(half);
    end
    if (cmd_i.calc) begin
      val_q  <= val_d;
      res_q  <= res_d;
      kind_q <= kind_d;
      upd_q  <= upd_d;
    end
    if (cmd_i.commit) begin
      out_pos_q <= ((act_q == ACT_START) || (kind_q == FK_MOD)) ? fin[POS_W-1:0] : res_q;
    end
  end

  // status towards the controller
  always_comb begin
    sts_o.need_rand = (mode_q == MODE_NEARBY) || (mode_q == MODE_JITTER);
    sts_o.need_div  = need_div;
    sts_o.div_busy  = div_busy;
    sts_o.div_done  = div_done;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;

endmodule

@@ hdl/mapg_ctrl.sv @@
// ----------------------------------------------------------------------------
// mapg_ctrl
// controller: walks each request through the random range step, the pattern
// arithmetic, the fold step and the result transfer
// ----------------------------------------------------------------------------
`include "memory_access_position_generator_top_assert.svh"

module mapg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mapg_pkg::mapg_sts_t sts_i,
  output mapg_pkg::mapg_cmd_t cmd_o
);
  import mapg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RWAIT,
    S_CALC,
    S_FCHK,
    S_FWAIT,
    S_FIN
  } state_e;

  state_e state_q;

  // commands decoded from the state
  always_comb begin
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rand_go   = (state_q == S_CHECK) && sts_i.need_rand;
    cmd_o.rand_take = (state_q == S_RWAIT) && sts_i.div_done;
    cmd_o.calc      = (state_q == S_CALC);
    cmd_o.fold_go   = (state_q == S_FCHK) && sts_i.need_div;
    cmd_o.commit    = (state_q == S_FIN) && sts_i.out_free;
  end

  assign in_ready_o = (state_q == S_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:  if (in_valid_i) state_q <= S_CHECK;
        S_CHECK: state_q <= sts_i.need_rand ? S_RWAIT : S_CALC;
        S_RWAIT: if (sts_i.div_done) state_q <= S_CALC;
        S_CALC:  state_q <= S_FCHK;
        S_FCHK:  state_q <= sts_i.need_div ? S_FWAIT : S_FIN;
        S_FWAIT: if (sts_i.div_done) state_q <= S_FIN;
        S_FIN:   if (sts_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a division ends only while it is awaited
  `MAPG_ASSERT_SAME(a_done_in_wait, sts_i.div_done, (state_q == S_RWAIT) || (state_q == S_FWAIT), "division finished outside a wait state")
  // a division is never started over a running one
  `MAPG_ASSERT_SAME(a_start_idle_div, cmd_o.rand_go || cmd_o.fold_go, !sts_i.div_busy, "division started while busy")
  // a request transfer closes the request channel
  `MAPG_ASSERT_NEXT(a_load_blocks, cmd_o.load, !in_ready_o, "request channel open after a transfer")

endmodule

@@ hdl/memory_access_position_generator_top.sv @@
// ----------------------------------------------------------------------------
// memory_access_position_generator_top
// Gives the buffer offset of each access of a memory traffic pattern, one
// result per request. A request with action start sets the running position
// for the configured mode and returns it; action next returns the offset of
// the next access and, in the sequential, stride, reverse and jitter modes,
// moves the position on. Requests are handled one at a time. A request may
// make passes through the shared bit-serial remainder unit: one pass for the
// centered random term of the nearby and jitter modes, one for a fold by
// last_offset or for the random mode. The finished result sits in an output
// register, and the next request is taken while it waits for its transfer.
// Configuration writes belong between requests, with no result outstanding.
// ----------------------------------------------------------------------------
module memory_access_position_generator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mapg_in_if.sink                         in_if,
  mapg_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [mapg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mapg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mapg_pkg::*;

  mapg_cmd_t cmd;
  mapg_sts_t sts;
  logic      in_ready;

  // sequencing
  mapg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  mapg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (in_if.action),
    .random_value_i (in_if.random_value),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .position_o     (out_if.position)
  );

  assign in_if.ready = in_ready;

endmodule

@@ bench/tb_memory_access_position_generator_top.sv @@
// ----------------------------------------------------------------------------
// tb_memory_access_position_generator_top
// Self-checking bench for the access position generator. A predictor keeps
// its own copy of the registers and the running position, works out the
// position of every accepted request and queues it; each result transfer is
// checked against the oldest queued position. A short directed pass covers
// every mode with extreme settings, then random patterns run under many
// register settings with random request gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_memory_access_position_generator_top;
  import mapg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1700;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 120;

  // codes the package does not name
  localparam logic [MODE_W-1:0]    MODE_UNUSED  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG   = CFG_IDX_W'(CFG_LAST + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX  = '1;

  localparam logic [SOR_W-1:0]        HALF_MAX = '1;
  localparam logic [ASZ_W-1:0]        ASZ_MAX  = 21'd1048576;
  localparam logic [OFFSET_WIDTH-1:0] LAST_MAX = '1;
  localparam logic [RAND_W-1:0]       RAND_MAX = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mapg_in_if  req_if ();
  mapg_out_if res_if ();

  memory_access_position_generator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (req_if),
    .out_if     (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow registers and running position of the predictor
  logic [MODE_W-1:0]       pat_mode;
  logic [ASZ_W-1:0]        acc_size;
  logic [SOR_W-1:0]        hole;
  logic [JIT_W-1:0]        jitter;
  logic [OFFSET_WIDTH-1:0] last_off;
  longint                  run_pos;

  logic [POS_W-1:0] expected_positions[$];

  int errors;
  int sent_count;
  int result_count;
  int setting_count;
  int cycle_count = 0;
  int burst_left;
  bit gapless;
  bit junk_on;
  logic [7:0] modes_seen;

  // long result hold-off requests, served by the receiver process
  int hold_ticket;
  int hold_served = 0;
  int hold_left = 0;
  int stall_style = 0;
  int style_left = 0;
  int pat_cnt = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_positions.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // remainder where a zero divisor gives zero
  function automatic longint rem_or_zero(longint unsigned num, longint unsigned den);
    if (den == 0) return 0;
    return num % den;
  endfunction

  // -half + r mod (2 * half)
  function automatic longint centered_term(longint half, longint r);
    return -half + rem_or_zero(r, RANGE_FACTOR * half);
  endfunction

  // fold by mod last offset when above it
  function automatic longint fold_down(longint v);
    longint lim;
    lim = last_off;
    if (v > lim) return rem_or_zero(v, lim);
    return v;
  endfunction

  // two's complement wrap at the running position width
  function automatic longint wrap_cur(longint v);
    logic signed [CUR_W-1:0] t;
    t = v[CUR_W-1:0];
    return t;
  endfunction

  function automatic logic [POS_W-1:0] predict_position(logic act, logic [RAND_W-1:0] rv);
    longint cur, a, p, j, lim, r, d, tgt, v, res;
    cur = run_pos;
    a   = acc_size;
    p   = hole;
    j   = jitter;
    lim = last_off;
    r   = rv;
    res = 0;
    if (act == ACT_START) begin
      case (pat_mode)
        MODE_RANDOM:  run_pos = wrap_cur(rem_or_zero(r * RAND_SCALE, lim));
        MODE_STRIDE:  run_pos = wrap_cur(p);
        MODE_NEARBY:  run_pos = wrap_cur(centered_term(p, r));
        MODE_REVERSE: run_pos = wrap_cur(lim - p);
        MODE_JITTER:  run_pos = wrap_cur(fold_down(p + centered_term(j, r)));
        default:      run_pos = 0;
      endcase
      res = run_pos;
    end else begin
      case (pat_mode)
        MODE_SEQ: begin
          res = cur;
          run_pos = wrap_cur(fold_down(cur + a));
        end
        MODE_RANDOM: res = rem_or_zero(r * RAND_SCALE, lim);
        MODE_STRIDE: begin
          res = cur;
          run_pos = wrap_cur(fold_down(cur + a + p));
        end
        // nearby: step back the other way when the target leaves the buffer
        MODE_NEARBY: begin
          d   = centered_term(p, r);
          tgt = cur + d;
          d   = d + ((d < 0) ? -a : a);
          if (tgt < 0 || tgt > lim) tgt = cur - d;
          res = tgt;
        end
        // reverse: underflow wraps down from the last offset
        MODE_REVERSE: begin
          v   = cur - (a + p);
          res = cur;
          if (v < 0) v = lim - rem_or_zero(-v, lim);
          run_pos = wrap_cur(v);
        end
        MODE_JITTER: begin
          res = cur;
          run_pos = wrap_cur(fold_down(cur + a + p + centered_term(j, r)));
        end
        default: res = 0;
      endcase
    end
    return res[POS_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checking
  // ---------------------------------------------------------------------------

  // receiver ready: long hold-off on request, else a changing stall pattern
  always @(posedge clk_i) begin
    pat_cnt++;
    if (style_left <= 0) begin
      stall_style = $urandom_range(0, 2);
      style_left  = $urandom_range(50, 300);
    end
    style_left--;
    if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_ticket) begin
      hold_served = hold_ticket;
      hold_left   = HOLD_CYCLES - 1;
      res_if.ready <= 1'b0;
    end else begin
      case (stall_style)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= ($urandom_range(0, 2) != 0);
        default: res_if.ready <= (pat_cnt % 4 != 3);
      endcase
    end
  end

  // compare each result transfer with the oldest expected position
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      result_count++;
      if (expected_positions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %0d", $time,
                 res_if.position);
      end else if (res_if.position !== expected_positions[0]) begin
        errors++;
        $display("%0t: position mismatch, expected %0d actual %0d", $time,
                 $signed(expected_positions[0]), res_if.position);
        void'(expected_positions.pop_front());
      end else begin
        void'(expected_positions.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request transfer; bursts of random length with random gaps between
  task automatic send_request(input logic act, input logic [RAND_W-1:0] rv);
    int gap;
    if (burst_left <= 0) begin
      gap = gapless ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.random_value <= rv;
    do @(posedge clk_i); while (!req_if.ready);
    modes_seen[pat_mode] = 1'b1;
    expected_positions.push_back(predict_position(act, rv));
    sent_count++;
  endtask

  // stop requesting until every expected result has been transferred
  task automatic drain_results();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_positions.size() != 0) @(posedge clk_i);
  endtask

  // random bits above a register's width, when enabled
  function automatic logic [CFG_DATA_W-1:0] add_junk(logic [CFG_DATA_W-1:0] v, int w);
    logic [CFG_DATA_W-1:0] hi;
    hi = {CFG_DATA_W{1'b1}} << w;
    if (!junk_on) return v;
    return v | (CFG_DATA_W'($urandom) & hi);
  endfunction

  // write all registers while idle, plus one write to an unused index
  task automatic program_regs(input logic [MODE_W-1:0] m, input logic [ASZ_W-1:0] a,
                              input logic [SOR_W-1:0] p, input logic [JIT_W-1:0] j,
                              input logic [OFFSET_WIDTH-1:0] l);
    logic [CFG_DATA_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0]  idxs[5];
    drain_results();
    junk_on = ($urandom_range(0, 3) == 0);
    vals[0] = add_junk(CFG_DATA_W'(m), MODE_W);
    vals[1] = add_junk(CFG_DATA_W'(a), ASZ_W);
    vals[2] = add_junk(CFG_DATA_W'(p), SOR_W);
    vals[3] = add_junk(CFG_DATA_W'(j), JIT_W);
    vals[4] = add_junk(CFG_DATA_W'(l), OFFSET_WIDTH);
    idxs = '{CFG_MODE, CFG_ASZ, CFG_STRIDE, CFG_JITTER, CFG_LAST};
    // a write beyond the register list must change nothing
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_IDX_W'($urandom_range(CFG_NO_REG, CFG_TOP_IDX));
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    for (int i = 0; i < 5; i++) begin
      cfg_idx_i  <= idxs[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    pat_mode = m;
    acc_size = a;
    hole     = p;
    jitter   = j;
    last_off = l;
    setting_count++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers as they come out of reset
  task automatic test_reset_values();
    send_request(ACT_START, RAND_MAX);
    send_request(ACT_NEXT, '0);
  endtask

  // one mode: start and two steps under a fixed setting
  task automatic run_directed(input logic [MODE_W-1:0] m, input logic [ASZ_W-1:0] a,
                              input logic [SOR_W-1:0] p, input logic [JIT_W-1:0] j,
                              input logic [OFFSET_WIDTH-1:0] l,
                              input logic [RAND_W-1:0] r0, input logic [RAND_W-1:0] r1,
                              input logic [RAND_W-1:0] r2);
    program_regs(m, a, p, j, l);
    send_request(ACT_START, r0);
    send_request(ACT_NEXT, r1);
    send_request(ACT_NEXT, r2);
  endtask

  task automatic test_each_mode();
    run_directed(MODE_ZERO, 21'd1, HALF_MAX, HALF_MAX, LAST_MAX, RAND_MAX, '0, RAND_MAX);
    // sequential fold on the second step
    run_directed(MODE_SEQ, ASZ_MAX, '0, '0, 32'd1500000, '0, RAND_MAX, '0);
    // random with a zero last offset
    run_directed(MODE_RANDOM, 21'd4096, '0, '0, '0, RAND_MAX, RAND_MAX, '0);
    run_directed(MODE_STRIDE, ASZ_MAX, HALF_MAX, '0, LAST_MAX, '0, '0, RAND_MAX);
    // nearby target leaving a tiny buffer at the low end
    run_directed(MODE_NEARBY, ASZ_MAX, HALF_MAX, '0, 32'd100, RAND_MAX, '0, RAND_MAX);
    // reverse stride underflow wraps from the top
    run_directed(MODE_REVERSE, 21'd4096, 31'd3000, '0, 32'd10000, '0, RAND_MAX, '0);
    // jitter with a zero range, then the unused mode code
    run_directed(MODE_JITTER, 21'd1, 31'd5, '0, LAST_MAX, RAND_MAX, RAND_MAX, '0);
    run_directed(MODE_UNUSED, ASZ_MAX, HALF_MAX, HALF_MAX, LAST_MAX, RAND_MAX, '0, '0);
  endtask

  function automatic logic [RAND_W-1:0] pick_rand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RAND_MAX;
      default: return RAND_W'($urandom);
    endcase
  endfunction

  function automatic logic [SOR_W-1:0] pick_half();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return HALF_MAX;
      2, 3:    return SOR_W'($urandom_range(1, 4096));
      4, 5:    return SOR_W'($urandom_range(1, 1 << 20));
      default: return SOR_W'($urandom);
    endcase
  endfunction

  function automatic logic [ASZ_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0:       return 21'd1;
      1:       return ASZ_MAX;
      default: return ASZ_W'($urandom_range(1, ASZ_MAX));
    endcase
  endfunction

  function automatic logic [OFFSET_WIDTH-1:0] pick_last();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return LAST_MAX;
      2, 3:    return OFFSET_WIDTH'($urandom_range(1, 1 << 16));
      4, 5:    return OFFSET_WIDTH'($urandom_range(1 << 16, 1 << 26));
      default: return OFFSET_WIDTH'($urandom);
    endcase
  endfunction

  // results held off long enough that requests back up at the input
  task automatic test_backpressure();
    program_regs(MODE_JITTER, pick_size(), pick_half(), pick_half(), pick_last());
    gapless = 1'b1;
    hold_ticket++;
    send_request(ACT_START, pick_rand());
    for (int i = 0; i < 40; i++) send_request(ACT_NEXT, pick_rand());
    drain_results();
    gapless = 1'b0;
  endtask

  // random settings; mostly a start followed by steps, some mixed noise
  task automatic test_random_patterns();
    int  len;
    bit  well_formed;
    logic act;
    while (sent_count < ITEM_TARGET) begin
      program_regs(MODE_W'($urandom_range(0, 7)), pick_size(), pick_half(), pick_half(),
                   pick_last());
      gapless     = ($urandom_range(0, 3) == 0);
      well_formed = ($urandom_range(0, 4) != 0);
      len         = $urandom_range(10, 70);
      for (int i = 0; i < len; i++) begin
        if (well_formed)
          act = (i == 0 || $urandom_range(0, 15) == 0) ? ACT_START : ACT_NEXT;
        else
          act = ($urandom_range(0, 1) == 0) ? ACT_START : ACT_NEXT;
        send_request(act, pick_rand());
      end
    end
    gapless = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors        = 0;
    sent_count    = 0;
    result_count  = 0;
    setting_count = 0;
    burst_left    = 0;
    gapless       = 1'b0;
    junk_on       = 1'b0;
    modes_seen    = '0;
    hold_ticket   = 0;

    // predictor follows the reset values
    pat_mode = MODE_RESET;
    acc_size = ASZ_RESET;
    hole     = '0;
    jitter   = '0;
    last_off = '0;
    run_pos  = 0;

    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_MODE;
    cfg_data_i          <= '0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_START;
    req_if.random_value <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_each_mode();
    test_backpressure();
    test_random_patterns();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_positions.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time,
               expected_positions.size());
    end

    $display("run covered %0d requests and %0d results under %0d register settings",
             sent_count, result_count, setting_count);
    $display("mode codes exercised %b, %0d long result hold-off(s), %0d cycles",
             modes_seen, hold_ticket, cycle_count);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
